@@ hdl/ssl_pkg.sv @@
// Shared types, constants and curve-table builder for the steering slew limiter.
package ssl_pkg;

  // Axis full scale in Q2.14
  localparam logic signed [15:0] AXIS_POS = 16'sd16384;
  localparam logic signed [15:0] AXIS_NEG = -16'sd16384;

  // Width of a per-tick slew step in Q2.14 (rate Q8.8 times tick Q0.16, shifted by 10)
  localparam int STEP_W = 22;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND_ON_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTERING_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FADE     = 2'd2;

  // Register reset values
  localparam logic [15:0] WIND_ON_RATE_RST   = 16'd666;
  localparam logic [15:0] CENTERING_RATE_RST = 16'd1536;
  localparam logic [15:0] SPEED_FADE_RST     = 16'd2294;

  // Speed fade: factor = 0.30 + 0.70 / (1 + |speed| * fade), all Q0.16
  localparam logic [31:0] DEN_ONE     = 32'h0100_0000;
  localparam logic [39:0] NUM_BASE    = 40'd45875 << 24;
  localparam logic [16:0] FACTOR_BASE = 17'd19661;

  // Decoupling queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Response curve exponent fraction (0.55 in 20 bits) and Q30 helpers
  localparam logic [19:0]   EXP_FRAC_BITS = 20'h8CCCC;
  localparam longint unsigned Q30_HALF    = 64'd1 << 29;

  // One classified item handed from front to back
  typedef struct packed {
    logic signed [15:0]  target;
    logic [STEP_W-1:0]   wind_step;
    logic [STEP_W-1:0]   cent_step;
    logic                recenter;
  } ssl_cmd_t;

  // Floor square root of a 64-bit value, elaboration only
  function automatic longint unsigned sqrt_floor(longint unsigned n_in);
    longint unsigned n;
    longint unsigned res;
    longint unsigned bitv;
    n    = n_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Curve entry 16384 * x^1.55 for x in Q30, by chained square roots
  function automatic logic [15:0] curve_entry(longint unsigned x);
    longint unsigned r;
    longint unsigned y;
    r = x;
    y = x;
    for (int b = 19; b >= 0; b--) begin
      r = sqrt_floor(r << 30);
      if (EXP_FRAC_BITS[b]) begin
        y = (y * r) >> 30;
      end
    end
    return 16'((y * 64'd16384 + Q30_HALF) >> 30);
  endfunction

endpackage

@@ hdl/ssl_if.sv @@
// Valid/ready channel interfaces for steering items and shaped results.
interface ssl_in_if;
  import ssl_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [15:0] target_position;
  logic signed [15:0] vehicle_speed;
  logic [15:0]        tick_length;
  logic               recenter;

  modport source (output valid, output target_position, output vehicle_speed,
                  output tick_length, output recenter, input ready);
  modport sink   (input valid, input target_position, input vehicle_speed,
                  input tick_length, input recenter, output ready);
endinterface

interface ssl_out_if;
  import ssl_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [15:0] shaped_steer;

  modport source (output valid, output shaped_steer, input ready);
  modport sink   (input valid, input shaped_steer, output ready);
endinterface

@@ hdl/steering_slew_limiter.sv @@
// Steering slew limiter: one axis slewed toward a target, shaped by a power curve.
//
// Channels: in_ch carries target_position, vehicle_speed, tick_length and
// recenter; out_ch returns one shaped_steer per accepted item, in order.
// Both use valid/ready; a transaction completes when both are high.
// cfg_we/cfg_index/cfg_wdata write wind_on_rate (0), centering_rate (1) and
// speed_fade (2); other indexes are ignored. Write only while idle.
// The front end takes a new item only after pushing the last, so its pace is
// set by the restoring divider that forms the speed fade factor; a recenter
// item skips the divider, and a run of recenters is paced by the back end.
// A two-entry queue sits between the front end and the axis back end, and
// the result sits in an output register, so the next item is accepted while
// a result waits; if out_ch.ready stays low the queue fills and in_ch.ready
// drops. Reset (rst_n low, synchronous) zeroes the axis, empties the queue
// and loads the register defaults; the curve ROM is constant.
module steering_slew_limiter #(
  parameter int CURVE_TABLE_SIZE = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ssl_in_if.sink                         in_ch,
  ssl_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import ssl_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  ssl_cmd_t push_cmd, pop_cmd;

  // Front end: accept, classify, compute steps
  ssl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decoupling queue
  ssl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Back end: axis update and curve shaping
  ssl_back #(
    .CURVE_TABLE_SIZE (CURVE_TABLE_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_ch    (out_ch)
  );

endmodule

@@ hdl/ssl_front.sv @@
// Front end: accepts items, holds config, computes wind-on and centering steps.
module ssl_front (
  input  logic                           clk,
  input  logic                           rst_n,
  ssl_in_if.sink                         in_ch,
  input  logic                           cfg_we,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata,
  output logic                           push_valid,
  input  logic                           push_ready,
  output ssl_pkg::ssl_cmd_t              push_cmd
);
  import ssl_pkg::*;

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_PROD = 7'b0000010,
    F_LOAD = 7'b0000100,
    F_DIV  = 7'b0001000,
    F_RATE = 7'b0010000,
    F_STEP = 7'b0100000,
    F_PUSH = 7'b1000000
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic [15:0]        wind_r, cent_r, fade_r;
  logic signed [15:0] tgt_r;
  logic [15:0]        sp_r, dt_r;
  logic               rc_r;
  logic [STEP_W-1:0]  cstep_r, wstep_r;
  logic [31:0]        den_r, rem_r;
  logic [15:0]        nlo_r, q_r;
  logic [3:0]         cnt_r;
  logic [15:0]        rate_r;

  logic signed [15:0] tgt_clamp;
  logic [15:0]        sp_abs;
  logic [31:0]        cent_prod;
  logic [39:0]        num_full;
  logic [32:0]        trial;
  logic               qbit;
  logic [16:0]        factor;
  logic [32:0]        rate_prod;
  logic [31:0]        wind_prod;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wind_r <= WIND_ON_RATE_RST;
      cent_r <= CENTERING_RATE_RST;
      fade_r <= SPEED_FADE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIND_ON_RATE:   wind_r <= cfg_wdata;
        CFG_CENTERING_RATE: cent_r <= cfg_wdata;
        CFG_SPEED_FADE:     fade_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input classification: clamp target, take speed magnitude, centering step
  always_comb begin
    if (in_ch.target_position > AXIS_POS) begin
      tgt_clamp = AXIS_POS;
    end else if (in_ch.target_position < AXIS_NEG) begin
      tgt_clamp = AXIS_NEG;
    end else begin
      tgt_clamp = in_ch.target_position;
    end
    sp_abs    = in_ch.vehicle_speed[15] ? 16'(-in_ch.vehicle_speed)
                                        : 16'(in_ch.vehicle_speed);
    cent_prod = 32'(cent_r) * 32'(in_ch.tick_length) + 32'd512;
  end

  // Datapath helpers for division, rate and step
  always_comb begin
    num_full  = NUM_BASE + 40'(den_r >> 1);
    trial     = {rem_r, nlo_r[15]};
    qbit      = (trial >= {1'b0, den_r});
    factor    = FACTOR_BASE + 17'(q_r);
    rate_prod = 33'(wind_r) * 33'(factor) + 33'd32768;
    wind_prod = 32'(rate_r) * 32'(dt_r) + 32'd512;
  end

  assign in_ch.ready = (state_r == F_IDLE);
  assign push_valid  = (state_r == F_PUSH);
  assign push_cmd    = '{target: tgt_r, wind_step: wstep_r, cent_step: cstep_r,
                         recenter: rc_r};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_ch.valid) begin
        state_nxt = in_ch.recenter ? F_PUSH : F_PROD;
      end
      F_PROD: state_nxt = F_LOAD;
      F_LOAD: state_nxt = F_DIV;
      F_DIV:  if (cnt_r == 4'd15) begin
        state_nxt = F_RATE;
      end
      F_RATE: state_nxt = F_STEP;
      F_STEP: state_nxt = F_PUSH;
      F_PUSH: if (push_ready) begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: if (in_ch.valid) begin
        tgt_r   <= tgt_clamp;
        sp_r    <= sp_abs;
        dt_r    <= in_ch.tick_length;
        rc_r    <= in_ch.recenter;
        cstep_r <= STEP_W'(cent_prod >> 10);
        wstep_r <= '0;
      end
      F_PROD: den_r <= DEN_ONE + 32'(sp_r) * 32'(fade_r);
      F_LOAD: begin
        rem_r <= 32'(num_full >> 16);
        nlo_r <= num_full[15:0];
        q_r   <= '0;
        cnt_r <= '0;
      end
      // Restoring division, one quotient bit per cycle
      F_DIV: begin
        rem_r <= qbit ? 32'(trial - {1'b0, den_r}) : 32'(trial);
        nlo_r <= {nlo_r[14:0], 1'b0};
        q_r   <= {q_r[14:0], qbit};
        cnt_r <= cnt_r + 4'd1;
      end
      F_RATE: rate_r  <= 16'(rate_prod >> 16);
      F_STEP: wstep_r <= STEP_W'(wind_prod >> 10);
      default: ;
    endcase
  end

endmodule

@@ hdl/ssl_queue.sv @@
// Short FIFO that decouples the front end from the axis back end.
module ssl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  ssl_pkg::ssl_cmd_t  push_cmd,
  output logic               pop_valid,
  input  logic               pop_ready,
  output ssl_pkg::ssl_cmd_t  pop_cmd
);
  import ssl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ssl_cmd_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_r, rptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/ssl_back.sv @@
// Back end: axis slew update, curve lookup with interpolation, output register.
module ssl_back #(
  parameter int CURVE_TABLE_SIZE = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  ssl_pkg::ssl_cmd_t  pop_cmd,
  ssl_out_if.source          out_ch
);
  import ssl_pkg::*;

  localparam int IDX_W  = $clog2(CURVE_TABLE_SIZE + 1);
  localparam int PROD_W = 15 + IDX_W;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_ADDR = 4'b0010,
    B_READ = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;

  // Curve ROM, built at elaboration
  logic [15:0] curve_rom [CURVE_TABLE_SIZE + 1];

  for (genvar g = 0; g <= CURVE_TABLE_SIZE; g++) begin : g_curve
    localparam longint unsigned XQ30 = (longint'(g) << 30) / CURVE_TABLE_SIZE;
    localparam logic [15:0] CurveVal = curve_entry(XQ30);
    assign curve_rom[g] = CurveVal;
  end

  logic signed [15:0] axis_r, axis_nxt;
  logic [IDX_W-1:0]   idx_lo_r, idx_hi_r;
  logic [13:0]        fr_r;
  logic               neg_r;
  logic [15:0]        lo_r, hi_r;
  logic               out_valid_r;
  logic signed [15:0] out_r;

  logic signed [23:0] pos_w, tgt_w, apos_w, atgt_w, step_w, diff_w, npos_w;
  logic               unwind;
  logic [16:0]        amag;
  logic [PROD_W-1:0]  pscaled;
  logic [IDX_W-1:0]   idx;
  logic signed [16:0] delta;
  logic signed [31:0] interp;
  logic [15:0]        mag16;
  logic               out_free;

  // Slew update: pick rate by direction, limit move, saturate; recenter zeroes the axis
  always_comb begin
    pos_w  = 24'(axis_r);
    tgt_w  = 24'(pop_cmd.target);
    apos_w = (pos_w < 0) ? -pos_w : pos_w;
    atgt_w = (tgt_w < 0) ? -tgt_w : tgt_w;
    unwind = (atgt_w < apos_w) || (tgt_w < 0 && pos_w > 0) || (tgt_w > 0 && pos_w < 0);
    step_w = unwind ? signed'({2'b00, pop_cmd.cent_step})
                    : signed'({2'b00, pop_cmd.wind_step});
    diff_w = tgt_w - pos_w;
    if (diff_w > step_w) begin
      diff_w = step_w;
    end
    if (diff_w < -step_w) begin
      diff_w = -step_w;
    end
    npos_w = pos_w + diff_w;
    if (npos_w > 24'(AXIS_POS)) begin
      npos_w = 24'(AXIS_POS);
    end
    if (npos_w < 24'(AXIS_NEG)) begin
      npos_w = 24'(AXIS_NEG);
    end
    axis_nxt = pop_cmd.recenter ? '0 : 16'(npos_w);
  end

  // Table index and fraction from |axis|
  always_comb begin
    amag    = axis_r[15] ? 17'(-17'(axis_r)) : 17'(axis_r);
    pscaled = PROD_W'(amag[14:0]) * PROD_W'(CURVE_TABLE_SIZE);
    idx     = pscaled[IDX_W+13:14];
  end

  // Linear interpolation between neighboring entries
  always_comb begin
    delta  = signed'({1'b0, hi_r}) - signed'({1'b0, lo_r});
    interp = (32'(delta) * 32'(signed'({1'b0, fr_r})) + 32'sd8192) >>> 14;
    mag16  = lo_r + 16'(interp);
  end

  assign out_free     = !out_valid_r || out_ch.ready;
  assign pop_ready    = (state_r == B_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.shaped_steer = out_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (pop_valid) begin
        state_nxt = B_ADDR;
      end
      B_ADDR: state_nxt = B_READ;
      B_READ: state_nxt = B_OUT;
      B_OUT:  if (out_free) begin
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state: FSM, axis and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_IDLE && pop_valid) begin
        axis_r <= axis_nxt;
      end
      if (state_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Lookup pipeline payload
  always_ff @(posedge clk) begin
    case (state_r)
      B_ADDR: begin
        idx_lo_r <= idx;
        idx_hi_r <= (idx == IDX_W'(CURVE_TABLE_SIZE)) ? idx : IDX_W'(idx + 1'b1);
        fr_r     <= pscaled[13:0];
        neg_r    <= axis_r[15];
      end
      B_READ: begin
        lo_r <= curve_rom[idx_lo_r];
        hi_r <= curve_rom[idx_hi_r];
      end
      B_OUT: if (out_free) begin
        out_r <= neg_r ? signed'(16'd0 - mag16) : signed'(mag16);
      end
      default: ;
    endcase
  end

endmodule
